// File: hw/rtl/i2cbb_pkg.sv
// i2cbb_pkg: types and constants for the bit-bang I2C master.
// Shared by the input stage, the phase engine, the output stage and the top level.
`default_nettype none

package i2cbb_pkg;

    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_NONE  = 3'd0;
    localparam cmd_t CMD_START = 3'd1;
    localparam cmd_t CMD_STOP  = 3'd2;
    localparam cmd_t CMD_WRITE = 3'd3;
    localparam cmd_t CMD_READ  = 3'd4;

    localparam logic       REG_HALF_PERIOD   = 1'b0;
    localparam logic       REG_STRETCH_LIMIT = 1'b1;
    localparam logic [15:0] HALF_PERIOD_RESET  = 16'd10;
    localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_SETUP      = 7'b0000010,
        PH_STRETCH    = 7'b0000100,
        PH_HIGH       = 7'b0001000,
        PH_START_LOW  = 7'b0010000,
        PH_START_HOLD = 7'b0100000,
        PH_STOP_REL   = 7'b1000000
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       stretch_timeout;
    } res_item_t;

    typedef struct packed {
        logic        we;
        logic        idx;
        logic [15:0] wdata;
    } cfg_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2cbb_in_stage.sv
// i2cbb_in_stage: input register for one beat of line samples and command.
// Depends on i2cbb_pkg.
`default_nettype none

module i2cbb_in_stage
    import i2cbb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_item_t item_in,
    input  wire logic     advance,
    output logic          step,
    output in_item_t      item_q
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign item_stall = valid_reg && !advance;
    assign step       = valid_reg && advance;
    assign item_q     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!item_stall)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/i2cbb_fsm.sv
// i2cbb_fsm: configuration registers, bus phase machine and line drive.
// Advances one tick per beat. Depends on i2cbb_pkg.
`default_nettype none

module i2cbb_fsm
    import i2cbb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_wr_t  cfg,
    input  wire logic     step,
    input  wire in_item_t item,
    output res_item_t     res
);

    logic [15:0] half_period_reg;
    logic [15:0] stretch_limit_reg;

    phase_t      phase_reg,         phase_next;
    cmd_t        active_cmd_reg,    active_cmd_next;
    logic [3:0]  bit_count_reg,     bit_count_next;
    logic [7:0]  shift_reg_reg,     shift_reg_next;
    logic [15:0] phase_timer_reg,   phase_timer_next;
    logic [15:0] stretch_timer_reg, stretch_timer_next;
    logic        bus_started_reg,   bus_started_next;
    logic        ack_bit_reg,       ack_bit_next;
    logic        ack_to_send_reg,   ack_to_send_next;
    logic        timeout_reg,       timeout_next;
    logic [7:0]  last_rx_reg,       last_rx_next;

    logic [15:0] hp;
    logic [16:0] timer_inc;
    logic        hold_done;
    logic        done;
    logic        data_drive;
    logic        scl_o;
    logic        sda_o;

    assign hp        = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign timer_inc = {1'b0, phase_timer_reg} + 17'd1;
    assign hold_done = timer_inc >= {1'b0, hp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HALF_PERIOD_RESET;
            stretch_limit_reg <= STRETCH_LIMIT_RESET;
        end
        else if (cfg.we)
        begin
            if (cfg.idx == REG_HALF_PERIOD)
            begin
                half_period_reg <= cfg.wdata;
            end
            else
            begin
                stretch_limit_reg <= cfg.wdata;
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        active_cmd_next    = active_cmd_reg;
        bit_count_next     = bit_count_reg;
        shift_reg_next     = shift_reg_reg;
        phase_timer_next   = phase_timer_reg;
        stretch_timer_next = stretch_timer_reg;
        bus_started_next   = bus_started_reg;
        ack_bit_next       = ack_bit_reg;
        ack_to_send_next   = ack_to_send_reg;
        timeout_next       = timeout_reg;
        last_rx_next       = last_rx_reg;
        done               = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.cmd == CMD_START || item.cmd == CMD_STOP ||
                    item.cmd == CMD_WRITE || item.cmd == CMD_READ)
                begin
                    active_cmd_next    = item.cmd;
                    timeout_next       = 1'b0;
                    bit_count_next     = 4'd0;
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                    if (item.cmd == CMD_WRITE)
                    begin
                        shift_reg_next = item.tx_byte;
                    end
                    if (item.cmd == CMD_READ)
                    begin
                        shift_reg_next   = 8'd0;
                        ack_to_send_next = item.send_ack;
                    end
                    if (item.cmd == CMD_START && !bus_started_reg)
                    begin
                        phase_next = PH_START_LOW;
                    end
                    else
                    begin
                        phase_next = PH_SETUP;
                    end
                end
            end
            PH_SETUP:
            begin
                if (hold_done)
                begin
                    phase_next         = PH_STRETCH;
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                end
                else
                begin
                    phase_timer_next = timer_inc[15:0];
                end
            end
            PH_STRETCH:
            begin
                if (item.scl_in || stretch_timer_reg >= stretch_limit_reg)
                begin
                    if (!item.scl_in)
                    begin
                        timeout_next = 1'b1;
                    end
                    phase_next         = PH_HIGH;
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                end
                else
                begin
                    stretch_timer_next = stretch_timer_reg + 16'd1;
                end
            end
            PH_HIGH:
            begin
                if (hold_done)
                begin
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                    if (active_cmd_reg == CMD_START)
                    begin
                        phase_next = PH_START_LOW;
                    end
                    else if (active_cmd_reg == CMD_STOP)
                    begin
                        phase_next = PH_STOP_REL;
                    end
                    else if (bit_count_reg < BITS_PER_BYTE)
                    begin
                        shift_reg_next = {shift_reg_reg[6:0],
                                          (active_cmd_reg == CMD_READ) && item.sda_in};
                        bit_count_next = bit_count_reg + 4'd1;
                        phase_next     = PH_SETUP;
                    end
                    else
                    begin
                        if (active_cmd_reg == CMD_WRITE)
                        begin
                            ack_bit_next = item.sda_in;
                        end
                        else
                        begin
                            last_rx_next = shift_reg_reg;
                        end
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    phase_timer_next = timer_inc[15:0];
                end
            end
            PH_START_LOW:
            begin
                if (hold_done)
                begin
                    phase_next         = PH_START_HOLD;
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                end
                else
                begin
                    phase_timer_next = timer_inc[15:0];
                end
            end
            PH_START_HOLD, PH_STOP_REL:
            begin
                if (hold_done)
                begin
                    bus_started_next   = (phase_reg == PH_START_HOLD);
                    done               = 1'b1;
                    phase_next         = PH_IDLE;
                    phase_timer_next   = 16'd0;
                    stretch_timer_next = 16'd0;
                end
                else
                begin
                    phase_timer_next = timer_inc[15:0];
                end
            end
            default:
            begin
                phase_next         = PH_IDLE;
                phase_timer_next   = 16'd0;
                stretch_timer_next = 16'd0;
            end
        endcase
    end

    // SDA level during bit cycles, from the updated state
    always_comb
    begin
        unique case (active_cmd_next)
            CMD_STOP:  data_drive = 1'b1;
            CMD_WRITE: data_drive = (bit_count_next < BITS_PER_BYTE) ?
                                    !shift_reg_next[7] : 1'b0;
            CMD_READ:  data_drive = (bit_count_next < BITS_PER_BYTE) ?
                                    1'b0 : !ack_to_send_next;
            default:   data_drive = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (phase_next)
            PH_SETUP:
            begin
                scl_o = 1'b1;
                sda_o = data_drive;
            end
            PH_STRETCH, PH_HIGH:
            begin
                scl_o = 1'b0;
                sda_o = data_drive;
            end
            PH_START_LOW:
            begin
                scl_o = 1'b0;
                sda_o = 1'b1;
            end
            PH_START_HOLD:
            begin
                scl_o = 1'b1;
                sda_o = 1'b1;
            end
            PH_STOP_REL:
            begin
                scl_o = 1'b0;
                sda_o = 1'b0;
            end
            default:
            begin
                scl_o = bus_started_next;
                sda_o = 1'b0;
            end
        endcase
    end

    assign res.scl_pull_low    = scl_o;
    assign res.sda_pull_low    = sda_o;
    assign res.busy_res        = (phase_next != PH_IDLE);
    assign res.done_res        = done;
    assign res.rx_byte         = last_rx_next;
    assign res.ack_seen        = ack_bit_next;
    assign res.stretch_timeout = timeout_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            active_cmd_reg    <= CMD_NONE;
            bit_count_reg     <= 4'd0;
            shift_reg_reg     <= 8'd0;
            phase_timer_reg   <= 16'd0;
            stretch_timer_reg <= 16'd0;
            bus_started_reg   <= 1'b0;
            ack_bit_reg       <= 1'b0;
            ack_to_send_reg   <= 1'b0;
            timeout_reg       <= 1'b0;
            last_rx_reg       <= 8'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            active_cmd_reg    <= active_cmd_next;
            bit_count_reg     <= bit_count_next;
            shift_reg_reg     <= shift_reg_next;
            phase_timer_reg   <= phase_timer_next;
            stretch_timer_reg <= stretch_timer_next;
            bus_started_reg   <= bus_started_next;
            ack_bit_reg       <= ack_bit_next;
            ack_to_send_reg   <= ack_to_send_next;
            timeout_reg       <= timeout_next;
            last_rx_reg       <= last_rx_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/i2cbb_out_stage.sv
// i2cbb_out_stage: result register that holds a beat while the consumer stalls.
// Depends on i2cbb_pkg.
`default_nettype none

module i2cbb_out_stage
    import i2cbb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire res_item_t res_in,
    output logic           advance,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_q
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t res_reg;

    assign advance   = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/i2c_bitbang_master.sv
// i2c_bitbang_master: top level of the open-drain bit-bang I2C master.
// Instantiates i2cbb_in_stage, i2cbb_fsm and i2cbb_out_stage; uses i2cbb_pkg.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   item    | item_valid / item_stall| cmd, tx_byte, send_ack, scl_in, sda_in
//   result  | res_valid / res_stall  | scl_pull_low, sda_pull_low, busy_res,
//           |                        | done_res, rx_byte, ack_seen, stretch_timeout
//   config  | cfg_we                 | cfg_idx, cfg_wdata
//
// One beat in per cycle while item_stall is low, one result beat out per item, through the
// input register, then phase update into the result register.
// rst_n clears the phase machine and both valid bits and loads the config defaults.
// A stalled result holds; the input register still takes one more beat.
`default_nettype none

module i2c_bitbang_master
    import i2cbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        send_ack,
    input  wire logic        scl_in,
    input  wire logic        sda_in,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             scl_pull_low,
    output logic             sda_pull_low,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       rx_byte,
    output logic             ack_seen,
    output logic             stretch_timeout,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [15:0] cfg_wdata
);

    in_item_t  item_in;
    in_item_t  item_q;
    res_item_t res_d;
    res_item_t res_q;
    cfg_wr_t   cfg;
    logic      step;
    logic      advance;

    assign item_in.cmd      = cmd;
    assign item_in.tx_byte  = tx_byte;
    assign item_in.send_ack = send_ack;
    assign item_in.scl_in   = scl_in;
    assign item_in.sda_in   = sda_in;

    assign cfg.we    = cfg_we;
    assign cfg.idx   = cfg_idx;
    assign cfg.wdata = cfg_wdata;

    i2cbb_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .advance    (advance),
        .step       (step),
        .item_q     (item_q)
    );

    i2cbb_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (item_q),
        .res   (res_d)
    );

    i2cbb_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_in    (res_d),
        .advance   (advance),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_q     (res_q)
    );

    assign scl_pull_low    = res_q.scl_pull_low;
    assign sda_pull_low    = res_q.sda_pull_low;
    assign busy_res        = res_q.busy_res;
    assign done_res        = res_q.done_res;
    assign rx_byte         = res_q.rx_byte;
    assign ack_seen        = res_q.ack_seen;
    assign stretch_timeout = res_q.stretch_timeout;

endmodule

`default_nettype wire

// File: hw/rtl/i2cbb_checker.sv
// i2cbb_checker: port-level checks on the result channel of the I2C master.
// Bound to i2c_bitbang_master; no package dependency.
`default_nettype none

module i2cbb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_stall,
    input wire logic       scl_pull_low,
    input wire logic       sda_pull_low,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] rx_byte
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(rx_byte) &&
            $stable(busy_res) && $stable(sda_pull_low))
        else $error("result beat changed while stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
        else $error("done beat reports busy");

    a_idle_sda_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> !sda_pull_low)
        else $error("SDA driven while idle");

    a_done_scl_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res && !done_res && $past(res_valid) &&
            !$past(res_stall) && !$past(busy_res) |-> $stable(scl_pull_low))
        else $error("SCL idle level changed without a command");

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .scl_pull_low (scl_pull_low),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rx_byte      (rx_byte)
);

`default_nettype wire

// File: tb/sv/tb_i2c_bitbang_master.sv
// Self-checking testbench for i2c_bitbang_master: directed command table, then random
// command streams under several timing settings, all checked beat by beat by a line model.
// Depends on i2cbb_pkg and the i2c_bitbang_master RTL only.
module tb_i2c_bitbang_master
    import i2cbb_pkg::*;
;

    localparam cmd_t CMD_RSVD_LO = 3'd5;
    localparam cmd_t CMD_RSVD_HI = 3'd7;
    localparam int   SDA_LOW     = 0;
    localparam int   SDA_HIGH    = 1;
    localparam int   SDA_RAND    = 2;

    typedef struct {
        cmd_t       c;
        logic [7:0] tx;
        logic       sa;
        int         lows;
        int         sda_mode;
        bit         typed;
        res_item_t  want;
    } cmd_row_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [2:0]  cmd        = CMD_NONE;
    logic [7:0]  tx_byte    = 8'h00;
    logic        send_ack   = 1'b0;
    logic        scl_in     = 1'b1;
    logic        sda_in     = 1'b1;
    logic        res_valid;
    logic        res_stall  = 1'b0;
    logic        scl_pull_low;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_seen;
    logic        stretch_timeout;
    logic        cfg_we     = 1'b0;
    logic        cfg_idx    = REG_HALF_PERIOD;
    logic [15:0] cfg_wdata  = 16'h0000;

    i2c_bitbang_master DUT (.*);

    // line model state
    logic [15:0] half_ticks  = HALF_PERIOD_RESET;
    logic [15:0] stretch_max = STRETCH_LIMIT_RESET;
    phase_t      ph          = PH_IDLE;
    cmd_t        cur_cmd     = CMD_NONE;
    logic [3:0]  bits_done   = 4'd0;
    logic [7:0]  sh          = 8'h00;
    int unsigned hold_cnt    = 0;
    int unsigned wait_cnt    = 0;
    logic        bus_owned   = 1'b0;
    logic        ack_rx      = 1'b0;
    logic        ack_out     = 1'b0;
    logic        tmo         = 1'b0;
    logic [7:0]  rx_hold     = 8'h00;

    res_item_t   pending_drive[$];
    cmd_row_t    plan[$];
    int          mismatches  = 0;
    int          beats_sent  = 0;
    bit          calm        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void enter_phase(phase_t p);
        ph = p;
        hold_cnt = 0;
        wait_cnt = 0;
    endfunction

    function automatic bit half_done();
        hold_cnt++;
        return hold_cnt >= ((half_ticks == 16'd0) ? 1 : half_ticks);
    endfunction

    function automatic logic sda_drive();
        case (cur_cmd)
            CMD_STOP:  return 1'b1;
            CMD_WRITE: return (bits_done < BITS_PER_BYTE) ? ~sh[7] : 1'b0;
            CMD_READ:  return (bits_done < BITS_PER_BYTE) ? 1'b0 : ~ack_out;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic res_item_t bus_tick(cmd_t c, logic [7:0] tx, logic sa,
                                           logic scl, logic sda);
        res_item_t r;
        logic      fin;
        fin = 1'b0;
        case (ph)
            PH_IDLE:
                if (c >= CMD_START && c <= CMD_READ)
                begin
                    cur_cmd = c;
                    tmo = 1'b0;
                    bits_done = 4'd0;
                    if (c == CMD_WRITE)
                        sh = tx;
                    if (c == CMD_READ)
                    begin
                        sh = 8'h00;
                        ack_out = sa;
                    end
                    if (c == CMD_START && !bus_owned)
                        enter_phase(PH_START_LOW);
                    else
                        enter_phase(PH_SETUP);
                end
            PH_SETUP:
                if (half_done())
                    enter_phase(PH_STRETCH);
            PH_STRETCH:
                if (scl)
                    enter_phase(PH_HIGH);
                else if (wait_cnt >= stretch_max)
                begin
                    tmo = 1'b1;
                    enter_phase(PH_HIGH);
                end
                else
                    wait_cnt++;
            PH_HIGH:
                if (half_done())
                begin
                    if (cur_cmd == CMD_START)
                        enter_phase(PH_START_LOW);
                    else if (cur_cmd == CMD_STOP)
                        enter_phase(PH_STOP_REL);
                    else if (bits_done < BITS_PER_BYTE)
                    begin
                        sh = {sh[6:0], (cur_cmd == CMD_READ) ? sda : 1'b0};
                        bits_done++;
                        enter_phase(PH_SETUP);
                    end
                    else
                    begin
                        if (cur_cmd == CMD_WRITE)
                            ack_rx = sda;
                        else
                            rx_hold = sh;
                        fin = 1'b1;
                        enter_phase(PH_IDLE);
                    end
                end
            PH_START_LOW:
                if (half_done())
                    enter_phase(PH_START_HOLD);
            PH_START_HOLD:
                if (half_done())
                begin
                    bus_owned = 1'b1;
                    fin = 1'b1;
                    enter_phase(PH_IDLE);
                end
            PH_STOP_REL:
                if (half_done())
                begin
                    bus_owned = 1'b0;
                    fin = 1'b1;
                    enter_phase(PH_IDLE);
                end
            default:
                enter_phase(PH_IDLE);
        endcase

        case (ph)
            PH_SETUP:
            begin
                r.scl_pull_low = 1'b1;
                r.sda_pull_low = sda_drive();
            end
            PH_STRETCH, PH_HIGH:
            begin
                r.scl_pull_low = 1'b0;
                r.sda_pull_low = sda_drive();
            end
            PH_START_LOW:
            begin
                r.scl_pull_low = 1'b0;
                r.sda_pull_low = 1'b1;
            end
            PH_START_HOLD:
            begin
                r.scl_pull_low = 1'b1;
                r.sda_pull_low = 1'b1;
            end
            PH_STOP_REL:
            begin
                r.scl_pull_low = 1'b0;
                r.sda_pull_low = 1'b0;
            end
            default:
            begin
                r.scl_pull_low = bus_owned;
                r.sda_pull_low = 1'b0;
            end
        endcase
        r.busy_res        = (ph != PH_IDLE);
        r.done_res        = fin;
        r.rx_byte         = rx_hold;
        r.ack_seen        = ack_rx;
        r.stretch_timeout = tmo;
        return r;
    endfunction

    function automatic res_item_t beat(logic scl, logic sda, logic busy, logic done,
                                       logic [7:0] rx, logic ack, logic to);
        res_item_t r;
        r.scl_pull_low    = scl;
        r.sda_pull_low    = sda;
        r.busy_res        = busy;
        r.done_res        = done;
        r.rx_byte         = rx;
        r.ack_seen        = ack;
        r.stretch_timeout = to;
        return r;
    endfunction

    // lows: ticks the slave holds SCL low in each stretch wait
    task automatic send(cmd_t c, logic [7:0] tx, logic sa, int lows, int sda_mode);
        logic scl_v;
        logic sda_v;
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        if (ph == PH_STRETCH)
            scl_v = (int'(wait_cnt) >= lows);
        else
            scl_v = 1'($urandom_range(0, 1));
        sda_v = (sda_mode == SDA_RAND) ? 1'($urandom_range(0, 1)) : (sda_mode == SDA_HIGH);
        cmd        <= c;
        tx_byte    <= tx;
        send_ack   <= sa;
        scl_in     <= scl_v;
        sda_in     <= sda_v;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pending_drive.push_back(bus_tick(c, tx, sa, scl_v, sda_v));
        beats_sent++;
    endtask

    task automatic run_row(cmd_row_t r);
        cmd_t f;
        send(r.c, r.tx, r.sa, r.lows, r.sda_mode);
        while (ph != PH_IDLE)
        begin
            f = ($urandom_range(0, 99) < 15) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
            send(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), r.lows,
                 r.sda_mode);
        end
        if (r.typed)
            pending_drive[pending_drive.size() - 1] = r.want;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_timing(logic [15:0] hp, logic [15:0] lim);
        drain();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_HALF_PERIOD;
        cfg_wdata <= hp;
        @(posedge clk);
        cfg_idx   <= REG_STRETCH_LIMIT;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        half_ticks  = hp;
        stretch_max = lim;
    endtask

    task automatic add_row(cmd_t c, logic [7:0] tx, logic sa, int lows, int sda_mode,
                           bit typed, res_item_t want);
        cmd_row_t r;
        r.c = c;
        r.tx = tx;
        r.sa = sa;
        r.lows = lows;
        r.sda_mode = sda_mode;
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endtask

    function automatic cmd_row_t pick_row();
        cmd_row_t r;
        int       k;
        int       cap;
        k = $urandom_range(0, 99);
        if (k < 8)
            r.c = cmd_t'($urandom_range(0, 7));
        else if (!bus_owned)
            r.c = CMD_START;
        else
        begin
            k = $urandom_range(0, 99);
            r.c = (k < 45) ? CMD_WRITE : (k < 75) ? CMD_READ : (k < 88) ? CMD_STOP : CMD_START;
        end
        cap = (stretch_max > 6) ? 8 : int'(stretch_max) + 2;
        r.tx = 8'($urandom_range(0, 255));
        r.sa = 1'($urandom_range(0, 1));
        r.lows = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, cap);
        r.sda_mode = SDA_RAND;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    task automatic sweep(logic [15:0] hp, logic [15:0] lim, int quota, bit quiet);
        cmd_row_t r;
        int       n;
        int       b0;
        set_timing(hp, lim);
        calm = quiet;
        n = 0;
        while (n < quota)
        begin
            r = pick_row();
            b0 = beats_sent;
            run_row(r);
            if (r.c >= CMD_START && r.c <= CMD_READ)
                n += beats_sent - b0;
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
        res_stall <= !calm && ($urandom_range(0, 99) < 10);

    task automatic cmp_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        res_item_t w;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_drive.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                w = pending_drive.pop_front();
                cmp_field("scl_pull_low", int'(w.scl_pull_low), int'(scl_pull_low));
                cmp_field("sda_pull_low", int'(w.sda_pull_low), int'(sda_pull_low));
                cmp_field("busy_res", int'(w.busy_res), int'(busy_res));
                cmp_field("done_res", int'(w.done_res), int'(done_res));
                cmp_field("rx_byte", int'(w.rx_byte), int'(rx_byte));
                cmp_field("ack_seen", int'(w.ack_seen), int'(ack_seen));
                cmp_field("stretch_timeout", int'(w.stretch_timeout),
                          int'(stretch_timeout));
            end
        end
    end

    initial
    begin
        cmd_row_t r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_timing(16'd2, 16'd3);

        // cmd, tx, send_ack, stretch lows, sda, typed, expected final beat
        add_row(CMD_NONE,    8'h00, 0, 0, SDA_HIGH, 1, beat(0, 0, 0, 0, 8'h00, 0, 0));
        add_row(CMD_RSVD_LO, 8'h00, 0, 0, SDA_HIGH, 1, beat(0, 0, 0, 0, 8'h00, 0, 0));
        add_row(CMD_RSVD_HI, 8'hFF, 1, 0, SDA_HIGH, 1, beat(0, 0, 0, 0, 8'h00, 0, 0));
        add_row(CMD_STOP,    8'h00, 0, 0, SDA_HIGH, 1, beat(0, 0, 0, 1, 8'h00, 0, 0));
        add_row(CMD_WRITE,   8'hA5, 0, 0, SDA_LOW,  0, '0);
        add_row(CMD_START,   8'h00, 0, 0, SDA_HIGH, 1, beat(1, 0, 0, 1, 8'h00, 0, 0));
        add_row(CMD_WRITE,   8'hFF, 0, 0, SDA_HIGH, 1, beat(1, 0, 0, 1, 8'h00, 1, 0));
        add_row(CMD_WRITE,   8'h00, 1, 0, SDA_LOW,  1, beat(1, 0, 0, 1, 8'h00, 0, 0));
        add_row(CMD_WRITE,   8'h80, 0, 2, SDA_LOW,  0, '0);
        add_row(CMD_WRITE,   8'h01, 0, 5, SDA_HIGH, 1, beat(1, 0, 0, 1, 8'h00, 1, 1));
        add_row(CMD_START,   8'h00, 0, 1, SDA_HIGH, 0, '0);
        add_row(CMD_READ,    8'h00, 1, 0, SDA_HIGH, 1, beat(1, 0, 0, 1, 8'hFF, 1, 0));
        add_row(CMD_READ,    8'hFF, 0, 0, SDA_LOW,  1, beat(1, 0, 0, 1, 8'h00, 1, 0));
        add_row(CMD_READ,    8'h5A, 1, 1, SDA_RAND, 0, '0);
        add_row(CMD_READ,    8'h00, 0, 4, SDA_RAND, 0, '0);
        add_row(CMD_STOP,    8'h00, 0, 0, SDA_RAND, 0, '0);
        add_row(CMD_READ,    8'h00, 1, 0, SDA_HIGH, 0, '0);
        add_row(CMD_START,   8'h00, 0, 0, SDA_RAND, 0, '0);
        add_row(CMD_STOP,    8'h00, 0, 3, SDA_RAND, 0, '0);
        foreach (plan[i])
            run_row(plan[i]);

        sweep(16'd1, 16'd2, 210, 1'b0);
        sweep(16'd0, 16'd0, 210, 1'b1);
        sweep(16'd3, 16'd5, 210, 1'b0);
        sweep(16'd2, 16'hFFFF, 210, 1'b0);

        // largest stretch limit: stop with a long clock stretch, then a start
        set_timing(16'd1, 16'hFFFF);
        r = pick_row();
        r.c = CMD_STOP;
        r.lows = 20;
        run_row(r);
        r.c = CMD_START;
        r.lows = 0;
        run_row(r);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
